>>> design/arpc_pkg.sv
package arpc_pkg;

  // Table depth default
  localparam int unsigned CacheEntriesDef = 16;

  // Subnet compare covers the first three octets
  localparam logic [31:0] SubnetMask = 32'hFFFF_FF00;
  localparam logic [10:0] MinArpLen  = 11'd28;
  localparam logic [15:0] ArpOpRequest = 16'd1;

  // Configuration register map
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 48;
  localparam logic [CfgIdxW-1:0] CfgOwnIp     = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgOwnMac    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgGatewayIp = 2'd2;

  localparam logic [31:0] OwnIpRst     = 32'h0A00_020F;
  localparam logic [31:0] GatewayIpRst = 32'h0A00_0202;

  // Request kinds
  localparam logic ReqResolve = 1'b0;
  localparam logic ReqArpPkt  = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [31:0] dest_ip;
    logic [10:0] packet_length;
    logic [15:0] arp_oper;
    logic [31:0] sender_ip;
    logic [47:0] sender_mac;
    logic [31:0] tgt_ip;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] next_hop_ip;
    logic [47:0] resolved_mac;
    logic        send_reply;
    logic [47:0] reply_mac;
    logic [31:0] reply_ip;
  } rsp_t;

  // Search probe handed from cell to cell
  typedef struct packed {
    logic        active;
    logic        hit;
    logic [31:0] key;
    logic [47:0] mac;
  } probe_t;

endpackage

>>> design/arpc_req_if.sv
interface arpc_req_if import arpc_pkg::*;;
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/arpc_rsp_if.sv
interface arpc_rsp_if import arpc_pkg::*;;
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/arpc_cell.sv
module arpc_cell import arpc_pkg::*; #(
  parameter int unsigned IdxW    = 4,
  parameter int unsigned CellIdx = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  probe_t          probe_i,
  input  logic [IdxW-1:0] idx_i,
  output probe_t          probe_o,
  output logic [IdxW-1:0] idx_o,
  input  logic            wr_en_i,
  input  logic [31:0]     wr_ip_i,
  input  logic [47:0]     wr_mac_i
);

  logic [31:0]     ip_q;
  logic [47:0]     mac_q;
  logic            valid_q;
  probe_t          probe_d;
  logic            active_q;
  logic            hit_q;
  logic [31:0]     key_q;
  logic [47:0]     found_mac_q;
  logic [IdxW-1:0] idx_d, idx_q;
  logic            match;

  // Claim the probe on the first valid match only
  assign match = probe_i.active && !probe_i.hit && valid_q && (ip_q == probe_i.key);

  always_comb begin
    probe_d = probe_i;
    idx_d   = idx_i;
    if (match) begin
      probe_d.hit = 1'b1;
      probe_d.mac = mac_q;
      idx_d       = IdxW'(CellIdx);
    end
  end

  // Hold the entry, valid once written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (wr_en_i) begin
      valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      ip_q  <= wr_ip_i;
      mac_q <= wr_mac_i;
    end
  end

  // Advance the probe one cell per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= probe_d.active;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q       <= probe_d.hit;
    key_q       <= probe_d.key;
    found_mac_q <= probe_d.mac;
    idx_q       <= idx_d;
  end

  assign probe_o = '{active: active_q, hit: hit_q, key: key_q, mac: found_mac_q};
  assign idx_o   = idx_q;

endmodule

>>> design/arp_cache_responder.sv
// ARP cache with responder. A resolve request picks the next hop (the
// destination when it shares the first three octets with own_ip, else the
// gateway) and returns its MAC from a table of CacheEntries bindings; an ARP
// packet of at least 28 bytes teaches the table the sender's binding and,
// when it is a request for own_ip, asks for a reply to the sender. The table
// is a row of cells; a search probe moves one cell per cycle, so a resolve or
// ARP packet walks the whole row before its result is registered, and a short
// packet skips the walk. One request is handled at a time; the next is
// accepted in the cycle after the result is loaded into the output register,
// even while that result waits to be taken, so no new request is taken while
// one is in progress. No clearing pass follows reset.
module arp_cache_responder import arpc_pkg::*; #(
  parameter int unsigned CacheEntries = CacheEntriesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  arpc_req_if.sink            req,
  arpc_rsp_if.source          rsp,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned IdxW = (CacheEntries > 1) ? $clog2(CacheEntries) : 1;
  localparam int unsigned CntW = $clog2(CacheEntries + 1);

  typedef enum logic [1:0] {
    StIdle,
    StWalk,
    StDone
  } state_e;

  state_e          state_q;
  logic [31:0]     own_ip_q, gateway_ip_q;
  logic [CntW-1:0] fill_q;
  req_t            req_q;
  logic [31:0]     hop_q;
  rsp_t            res_d, res_q;
  logic            rsp_valid_d, rsp_valid_q;
  rsp_t            rsp_data_q;

  probe_t                  chain [CacheEntries+1];
  logic [IdxW-1:0]         chain_idx [CacheEntries+1];
  logic [CacheEntries-1:0] wr_en;

  logic            accept;
  logic [31:0]     hop;
  logic            long_pkt;
  probe_t          tail;
  logic            tail_done;
  logic            wr_go;
  logic            table_full;
  logic [IdxW-1:0] slot;
  logic            out_free;

  // Configuration registers; a write to own_mac is accepted but not stored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q     <= OwnIpRst;
      gateway_ip_q <= GatewayIpRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgOwnIp:     own_ip_q     <= cfg_data_i[31:0];
        CfgOwnMac:    ;
        CfgGatewayIp: gateway_ip_q <= cfg_data_i[31:0];
        default:      ;
      endcase
    end
  end

  // Pick the next hop and start the probe
  assign req.ready = (state_q == StIdle);
  assign accept    = req.valid && req.ready;
  assign hop       = ((req.data.dest_ip & SubnetMask) == (own_ip_q & SubnetMask))
                     ? req.data.dest_ip : gateway_ip_q;
  assign long_pkt  = (req.data.packet_length >= MinArpLen);

  assign chain[0] = '{
    active: accept && ((req.data.req_type == ReqResolve) || long_pkt),
    hit:    1'b0,
    key:    (req.data.req_type == ReqResolve) ? hop : req.data.sender_ip,
    mac:    '0
  };
  assign chain_idx[0] = '0;

  for (genvar i = 0; i < CacheEntries; i++) begin : g_cell
    arpc_cell #(
      .IdxW    (IdxW),
      .CellIdx (i)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .probe_i  (chain[i]),
      .idx_i    (chain_idx[i]),
      .probe_o  (chain[i+1]),
      .idx_o    (chain_idx[i+1]),
      .wr_en_i  (wr_en[i]),
      .wr_ip_i  (req_q.sender_ip),
      .wr_mac_i (req_q.sender_mac)
    );
  end

  // Pick the slot to learn into: matching entry, next free, else entry 0
  assign tail       = chain[CacheEntries];
  assign tail_done  = (state_q == StWalk) && tail.active;
  assign wr_go      = tail_done && (req_q.req_type == ReqArpPkt);
  assign table_full = (fill_q == CntW'(CacheEntries));

  always_comb begin
    if (tail.hit) begin
      slot = chain_idx[CacheEntries];
    end else if (table_full) begin
      slot = '0;
    end else begin
      slot = fill_q[IdxW-1:0];
    end
  end

  for (genvar i = 0; i < CacheEntries; i++) begin : g_wr
    assign wr_en[i] = wr_go && (slot == IdxW'(i));
  end

  assign out_free = !rsp_valid_q || rsp.ready;

  // Drop a taken result, load the finished one when the register frees
  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (rsp_valid_q && rsp.ready) begin
      rsp_valid_d = 1'b0;
    end
    if ((state_q == StDone) && out_free) begin
      rsp_valid_d = 1'b1;
    end
  end

  // Sequence one request: walk, finish, hand to output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      fill_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
      if (wr_go && !tail.hit && !table_full) begin
        fill_q <= fill_q + CntW'(1);
      end
      case (state_q)
        StIdle: begin
          if (accept) begin
            state_q <= chain[0].active ? StWalk : StDone;
          end
        end
        StWalk: begin
          if (tail.active) begin
            state_q <= StDone;
          end
        end
        StDone: begin
          if (out_free) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Build the result: clear on acceptance, fill in when the probe leaves
  always_comb begin
    res_d = res_q;
    if (accept) begin
      res_d = '0;
    end
    if (tail_done) begin
      res_d = '0;
      if (req_q.req_type == ReqResolve) begin
        res_d.hit          = tail.hit;
        res_d.next_hop_ip  = hop_q;
        res_d.resolved_mac = tail.hit ? tail.mac : '0;
      end else if ((req_q.arp_oper == ArpOpRequest) && (req_q.tgt_ip == own_ip_q)) begin
        res_d.send_reply = 1'b1;
        res_d.reply_mac  = req_q.sender_mac;
        res_d.reply_ip   = req_q.sender_ip;
      end
    end
  end

  // Capture request, result and output data
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req.data;
      hop_q <= hop;
    end
    res_q <= res_d;
    if ((state_q == StDone) && out_free) begin
      rsp_data_q <= res_q;
    end
  end

  assign rsp.valid = rsp_valid_q;
  assign rsp.data  = rsp_data_q;

  // Checks
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(CacheEntries))
    else $error("fill count beyond table depth");

  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(wr_en))
    else $error("more than one table entry written");

  a_idle_no_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.ready |-> !tail.active)
    else $error("probe left the chain while idle");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q == StDone))
    else $error("result loaded outside the finish state");

endmodule
